### rtl/float_multiplier_configurable_core_macros.svh
// Assertion macros shared by the checker of the float multiplier core.
`ifndef FLOAT_MULTIPLIER_CONFIGURABLE_CORE_MACROS_SVH
`define FLOAT_MULTIPLIER_CONFIGURABLE_CORE_MACROS_SVH

// Checked at every rising edge outside reset.
`define FMC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fmc_pkg.sv
// Shared constants and types of the configurable float multiplier.
`default_nettype none
package fmc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int CFG_W         = 5;
  localparam int IDX_W         = 2;

  localparam logic [IDX_W-1:0] CFG_FRAC_W = 2'd0;
  localparam logic [IDX_W-1:0] CFG_EXP_W  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_RMODE  = 2'd2;

  localparam logic [4:0] FRAC_W_RST = 5'd23;
  localparam logic [4:0] EXP_W_RST  = 5'd8;

  localparam logic [2:0] RND_NEAREST = 3'd0;
  localparam logic [2:0] RND_GUARD   = 3'd1;
  localparam logic [2:0] RND_TRUNC   = 3'd2;
  localparam logic [2:0] RND_POS     = 3'd3;
  localparam logic [2:0] RND_NEG     = 3'd4;

  typedef struct packed {
    logic zero;
    logic ovf;
    logic unf;
    logic inx;
    logic nan;
  } fmc_flags_t;

endpackage
`default_nettype wire

### rtl/fmc_unpack.sv
// Operand decode: field extraction, special cases, significands and exponent sum.
`default_nettype none
module fmc_unpack #(
  parameter int WORD_BITS = fmc_pkg::WORD_BITS_DEF
) (
  input  wire logic [4:0]            fw_cfg,
  input  wire logic [4:0]            ew_cfg,
  input  wire logic [WORD_BITS-1:0]  op_a,
  input  wire logic [WORD_BITS-1:0]  op_b,
  output logic [4:0]                 fw,
  output logic [WORD_BITS-2:0]       emax,
  output logic                       sign,
  output logic [WORD_BITS-3:0]       ma,
  output logic [WORD_BITS-3:0]       mb,
  output logic signed [WORD_BITS+1:0] xsum,
  output logic                       special,
  output logic [WORD_BITS-1:0]       spec_word,
  output fmc_pkg::fmc_flags_t        spec_flags
);
  localparam int W  = WORD_BITS;
  localparam int XW = WORD_BITS + 2;
  localparam logic [4:0] FW_MAX = 5'(WORD_BITS - 3);
  localparam logic [4:0] EW_TOP = 5'(WORD_BITS - 1);

  logic [4:0]   ew_lim, ew;
  logic [W-2:0] fmask, bias, ea, eb, fa, fb, ma_w, mb_w, emax_sh;
  logic [W-1:0] sign_word, inf_word, nan_word;
  logic         za, zb, ia, ib, na, nb;
  logic signed [XW-1:0] fw_x, xa, xb, bias_x;

  always_comb begin
    fw = (fw_cfg < 5'd2) ? 5'd2 : ((fw_cfg > FW_MAX) ? FW_MAX : fw_cfg);
    ew_lim = EW_TOP - fw;
    ew = (ew_cfg < 5'd2) ? 5'd2 : ((ew_cfg > ew_lim) ? ew_lim : ew_cfg);
    emax  = ~({(W-1){1'b1}} << ew);
    fmask = ~({(W-1){1'b1}} << fw);
    bias  = emax >> 1;

    ea = op_a[W-2:0] >> fw & emax;
    eb = op_b[W-2:0] >> fw & emax;
    fa = op_a[W-2:0] & fmask;
    fb = op_b[W-2:0] & fmask;
    sign = op_a[W-1] ^ op_b[W-1];

    za = (ea == '0) && (fa == '0);
    zb = (eb == '0) && (fb == '0);
    ia = (ea == emax) && (fa == '0);
    ib = (eb == emax) && (fb == '0);
    na = (ea == emax) && (fa != '0);
    nb = (eb == emax) && (fb != '0);

    emax_sh   = emax << fw;
    sign_word = {sign, {(W-1){1'b0}}};
    inf_word  = {sign, emax_sh};
    nan_word  = {1'b0, emax_sh | ({{(W-2){1'b0}}, 1'b1} << (fw - 5'd1))};

    special    = 1'b1;
    spec_word  = sign_word;
    spec_flags = '0;
    if (na || nb) begin
      if ((za && nb) || (zb && na)) begin
        spec_flags.zero = 1'b1;
      end else begin
        spec_word      = nan_word;
        spec_flags.nan = 1'b1;
        spec_flags.inx = 1'b1;
      end
    end else if (ia || ib) begin
      if ((ia && zb) || (ib && za)) begin
        spec_word      = nan_word;
        spec_flags.nan = 1'b1;
        spec_flags.inx = 1'b1;
      end else begin
        spec_word      = inf_word;
        spec_flags.ovf = 1'b1;
      end
    end else if (za || zb) begin
      spec_flags.zero = 1'b1;
    end else begin
      special = 1'b0;
    end

    // Subnormals carry no hidden one and take an exponent of one minus the fraction width.
    ma_w = (ea == '0) ? fa : (({{(W-2){1'b0}}, 1'b1} << fw) | fa);
    mb_w = (eb == '0) ? fb : (({{(W-2){1'b0}}, 1'b1} << fw) | fb);
    ma = ma_w[W-3:0];
    mb = mb_w[W-3:0];

    fw_x   = $signed({{(XW-5){1'b0}}, fw});
    bias_x = $signed({3'b000, bias});
    xa = (ea == '0) ? ($signed(XW'(1)) - fw_x) : $signed({3'b000, ea});
    xb = (eb == '0) ? ($signed(XW'(1)) - fw_x) : $signed({3'b000, eb});
    xsum = xa + xb - bias_x;
  end
endmodule
`default_nettype wire

### rtl/fmc_round.sv
// Normalize and round stage, then overflow, subnormal shift and packing into the output register.
`default_nettype none
module fmc_round #(
  parameter int WORD_BITS = fmc_pkg::WORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_v,
  input  wire logic [2*WORD_BITS-5:0]     prod,
  input  wire logic [4:0]                 fw,
  input  wire logic [WORD_BITS-2:0]       emax,
  input  wire logic                       sign,
  input  wire logic [2:0]                 rmode,
  input  wire logic signed [WORD_BITS+1:0] xsum,
  input  wire logic                       special,
  input  wire logic [WORD_BITS-1:0]       spec_word,
  input  wire fmc_pkg::fmc_flags_t        spec_flags,
  output logic                            out_v,
  output logic [WORD_BITS-1:0]            out_word,
  output fmc_pkg::fmc_flags_t             out_flags
);
  localparam int W   = WORD_BITS;
  localparam int PW  = 2 * WORD_BITS - 4;
  localparam int XW  = WORD_BITS + 2;
  localparam int SHW = $clog2(WORD_BITS);

  // Rounding stage.
  logic          norm, guard, rbit, sticky, exact, inc, carry;
  logic [5:0]    drop;
  logic [PW-1:0] low, prod_n;
  logic [W-2:0]  sig, sig_i, fmask, frac;
  logic signed [XW-1:0] fexp;

  logic                 s_v_r;
  logic [W-2:0]         s_frac_r, s_emax_r;
  logic signed [XW-1:0] s_fexp_r;
  logic                 s_exact_r, s_sign_r, s_special_r;
  logic [4:0]           s_fw_r;
  logic [W-1:0]         s_spec_word_r;
  fmc_pkg::fmc_flags_t  s_spec_flags_r;

  always_comb begin
    prod_n = prod >> {fw, 1'b1};
    norm   = prod_n[0];
    drop   = {1'b0, fw} + {5'd0, norm};
    low    = ~({PW{1'b1}} << drop);
    guard  = |(prod & low & ~(low >> 1));
    rbit   = |(prod & (low >> 1) & ~(low >> 2));
    sticky = |(prod & (low >> 2));
    sig    = (W-1)'(prod >> drop);
    case (rmode)
      fmc_pkg::RND_NEAREST: inc = guard && (rbit || sticky || sig[0]);
      fmc_pkg::RND_GUARD:   inc = guard;
      fmc_pkg::RND_POS:     inc = guard && !sign;
      fmc_pkg::RND_NEG:     inc = guard && sign;
      default:              inc = 1'b0;
    endcase
    exact = ~|(prod & low) && !inc;
    sig_i = sig + {{(W-2){1'b0}}, inc};
    carry = |(sig_i & ({{(W-2){1'b0}}, 1'b1} << (fw + 5'd1)));
    if (carry) begin
      sig_i = sig_i >> 1;
    end
    fmask = ~({(W-1){1'b1}} << fw);
    frac  = sig_i & fmask;
    fexp  = xsum + $signed({{(XW-1){1'b0}}, norm}) + $signed({{(XW-1){1'b0}}, carry});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else begin
      s_v_r <= in_v;
    end
    s_frac_r       <= frac;
    s_fexp_r       <= fexp;
    s_exact_r      <= exact;
    s_sign_r       <= sign;
    s_fw_r         <= fw;
    s_emax_r       <= emax;
    s_special_r    <= special;
    s_spec_word_r  <= spec_word;
    s_spec_flags_r <= spec_flags;
  end

  // Packing stage.
  logic                 ovf, unf, st;
  logic signed [XW-1:0] shift, emax_x;
  logic [SHW-1:0]       sh;
  logic [W-2:0]         full, msk, sub, fm2, ex_sh;
  logic [W-1:0]         word_nxt;
  fmc_pkg::fmc_flags_t  flags_nxt;

  always_comb begin
    emax_x = $signed({3'b000, s_emax_r});
    ovf    = s_fexp_r >= emax_x;
    unf    = s_fexp_r <= $signed(XW'(0));
    shift  = $signed(XW'(1)) - s_fexp_r;
    sh     = (shift > $signed(XW'(W - 1))) ? SHW'(W - 1) : shift[SHW-1:0];
    fm2    = ~({(W-1){1'b1}} << s_fw_r);
    full   = ({{(W-2){1'b0}}, 1'b1} << s_fw_r) | s_frac_r;
    msk    = ~({(W-1){1'b1}} << sh);
    st     = |(full & msk);
    sub    = (full >> sh) & fm2;
    ex_sh  = s_fexp_r[W-2:0] << s_fw_r;

    flags_nxt = '0;
    if (s_special_r) begin
      word_nxt  = s_spec_word_r;
      flags_nxt = s_spec_flags_r;
    end else if (ovf) begin
      word_nxt      = {s_sign_r, s_emax_r << s_fw_r};
      flags_nxt.ovf = 1'b1;
      flags_nxt.inx = !s_exact_r;
    end else if (unf) begin
      word_nxt       = {s_sign_r, sub};
      flags_nxt.zero = (sub == '0);
      flags_nxt.unf  = 1'b1;
      flags_nxt.inx  = !s_exact_r || st;
    end else begin
      word_nxt      = {s_sign_r, ex_sh | s_frac_r};
      flags_nxt.inx = !s_exact_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else begin
      out_v <= s_v_r;
    end
    out_word  <= word_nxt;
    out_flags <= flags_nxt;
  end
endmodule
`default_nettype wire

### rtl/float_multiplier_configurable_core.sv
// Top level of the pipelined configurable float multiplier.
// Takes one operand pair per clock and returns each product with out_valid high
// for a single cycle, through the pipeline stages: decode, significand
// multiply, normalize and round, then pack into the output register. busy is
// always low and the receiver cannot stall. Format and rounding registers may
// be written only while no beat is in the four-stage pipeline.
`default_nettype none
module float_multiplier_configurable_core #(
  parameter int WORD_BITS = fmc_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [4:0]           cfg_data,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [WORD_BITS-1:0] in_operand_a,
  input  wire logic [WORD_BITS-1:0] in_operand_b,
  output logic                      out_valid,
  output logic [WORD_BITS-1:0]      out_product_word,
  output logic                      out_zero_flag,
  output logic                      out_overflow_flag,
  output logic                      out_underflow_flag,
  output logic                      out_inexact_flag,
  output logic                      out_nan_flag
);
  localparam int W  = WORD_BITS;
  localparam int MW = WORD_BITS - 2;
  localparam int PW = 2 * MW;
  localparam int XW = WORD_BITS + 2;

  logic [4:0] fw_cfg_r, ew_cfg_r;
  logic [2:0] rm_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_cfg_r <= fmc_pkg::FRAC_W_RST;
      ew_cfg_r <= fmc_pkg::EXP_W_RST;
      rm_cfg_r <= fmc_pkg::RND_NEAREST;
    end else if (cfg_we) begin
      case (cfg_index)
        fmc_pkg::CFG_FRAC_W: fw_cfg_r <= cfg_data;
        fmc_pkg::CFG_EXP_W:  ew_cfg_r <= cfg_data;
        fmc_pkg::CFG_RMODE:  rm_cfg_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [4:0]           d_fw;
  logic [W-2:0]         d_emax;
  logic                 d_sign, d_special;
  logic [MW-1:0]        d_ma, d_mb;
  logic signed [XW-1:0] d_xsum;
  logic [W-1:0]         d_spec_word;
  fmc_pkg::fmc_flags_t  d_spec_flags;

  fmc_unpack #(.WORD_BITS(WORD_BITS)) u_unpack (
    .fw_cfg     (fw_cfg_r),
    .ew_cfg     (ew_cfg_r),
    .op_a       (in_operand_a),
    .op_b       (in_operand_b),
    .fw         (d_fw),
    .emax       (d_emax),
    .sign       (d_sign),
    .ma         (d_ma),
    .mb         (d_mb),
    .xsum       (d_xsum),
    .special    (d_special),
    .spec_word  (d_spec_word),
    .spec_flags (d_spec_flags)
  );

  // Decode stage and multiply stage registers.
  logic                 s1_v_r, s2_v_r;
  logic [4:0]           s1_fw_r, s2_fw_r;
  logic [W-2:0]         s1_emax_r, s2_emax_r;
  logic                 s1_sign_r, s2_sign_r, s1_special_r, s2_special_r;
  logic [2:0]           s1_rm_r, s2_rm_r;
  logic [MW-1:0]        s1_ma_r, s1_mb_r;
  logic [PW-1:0]        s2_prod_r;
  logic signed [XW-1:0] s1_xsum_r, s2_xsum_r;
  logic [W-1:0]         s1_spec_word_r, s2_spec_word_r;
  fmc_pkg::fmc_flags_t  s1_spec_flags_r, s2_spec_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
      s2_v_r <= s1_v_r;
    end
    s1_fw_r         <= d_fw;
    s1_emax_r       <= d_emax;
    s1_sign_r       <= d_sign;
    s1_special_r    <= d_special;
    s1_rm_r         <= rm_cfg_r;
    s1_ma_r         <= d_ma;
    s1_mb_r         <= d_mb;
    s1_xsum_r       <= d_xsum;
    s1_spec_word_r  <= d_spec_word;
    s1_spec_flags_r <= d_spec_flags;

    s2_fw_r         <= s1_fw_r;
    s2_emax_r       <= s1_emax_r;
    s2_sign_r       <= s1_sign_r;
    s2_special_r    <= s1_special_r;
    s2_rm_r         <= s1_rm_r;
    s2_prod_r       <= s1_ma_r * s1_mb_r;
    s2_xsum_r       <= s1_xsum_r;
    s2_spec_word_r  <= s1_spec_word_r;
    s2_spec_flags_r <= s1_spec_flags_r;
  end

  fmc_pkg::fmc_flags_t o_flags;

  fmc_round #(.WORD_BITS(WORD_BITS)) u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (s2_v_r),
    .prod       (s2_prod_r),
    .fw         (s2_fw_r),
    .emax       (s2_emax_r),
    .sign       (s2_sign_r),
    .rmode      (s2_rm_r),
    .xsum       (s2_xsum_r),
    .special    (s2_special_r),
    .spec_word  (s2_spec_word_r),
    .spec_flags (s2_spec_flags_r),
    .out_v      (out_valid),
    .out_word   (out_product_word),
    .out_flags  (o_flags)
  );

  assign out_zero_flag      = o_flags.zero;
  assign out_overflow_flag  = o_flags.ovf;
  assign out_underflow_flag = o_flags.unf;
  assign out_inexact_flag   = o_flags.inx;
  assign out_nan_flag       = o_flags.nan;
endmodule
`default_nettype wire

### rtl/fmc_checker.sv
// Port-level checker for the float multiplier core and its bind.
`default_nettype none
`include "float_multiplier_configurable_core_macros.svh"
module fmc_checker #(
  parameter int WORD_BITS = fmc_pkg::WORD_BITS_DEF
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 cfg_we,
  input wire logic [1:0]           cfg_index,
  input wire logic [4:0]           cfg_data,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [WORD_BITS-1:0] in_operand_a,
  input wire logic [WORD_BITS-1:0] in_operand_b,
  input wire logic                 out_valid,
  input wire logic [WORD_BITS-1:0] out_product_word,
  input wire logic                 out_zero_flag,
  input wire logic                 out_overflow_flag,
  input wire logic                 out_underflow_flag,
  input wire logic                 out_inexact_flag,
  input wire logic                 out_nan_flag
);
  `FMC_ASSERT_ALWAYS(a_never_busy, !busy, "busy rose on a fully pipelined block")
  `FMC_ASSERT_RST(a_beat_has_start, out_valid |-> $past(start, 4), "result beat without a start four cycles earlier")
  `FMC_ASSERT_RST(a_nan_inexact, (out_valid && out_nan_flag) |-> (out_inexact_flag && !out_zero_flag && !out_product_word[WORD_BITS-1]), "NaN result with wrong flags or sign")
  `FMC_ASSERT_RST(a_zero_not_inf, out_valid |-> !(out_zero_flag && out_overflow_flag), "result flagged both zero and infinite")
endmodule

bind float_multiplier_configurable_core fmc_checker #(.WORD_BITS(WORD_BITS)) u_fmc_checker (.*);
`default_nettype wire
